// ----- src/lsj_pkg.sv -----
// Shared constants for the periodic lattice site jump block.
package lsj_pkg;

  localparam int SITE_BITS      = 24;
  localparam int REG_BITS       = 7;
  localparam int NUM_REGS       = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_EXTENT_DEF = 64;
  localparam int JUMP_BITS_DEF  = 8;

  localparam logic [REG_BITS-1:0] REG_RESET = REG_BITS'(16);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_T = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = CFG_IDX_W'(4);

endpackage

// ----- src/lsj_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module lsj_div #(
  parameter int N = 24,
  parameter int D = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quot,
  output logic [D-1:0] rem
);

  localparam int CNT_W = $clog2(N + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [N-1:0]     acc;
  logic [D-1:0]     rem_r;
  logic [D-1:0]     dvs;
  logic [D:0]       partial;
  logic [D:0]       diff;
  logic             ge;

  assign partial = {rem_r, acc[N-1]};
  assign diff    = partial - {1'b0, dvs};
  assign ge      = (partial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNT_W'(N);
        acc   <= dividend;
        dvs   <= divisor;
        rem_r <= '0;
      end else if (run) begin
        acc   <= {acc[N-2:0], ge};
        rem_r <= ge ? diff[D-1:0] : partial[D-1:0];
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = acc;
  assign rem  = rem_r;

endmodule

// ----- src/lsj_lane.sv -----
// One direction lane: add offset, floor-divide by extent, wrap and saturate count.
module lsj_lane #(
  parameter int COORD_W    = 24,
  parameter int JUMP_BITS  = 8,
  parameter int EXT_W      = 7,
  parameter int CO_W       = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [COORD_W-1:0]          coord,
  input  logic signed [JUMP_BITS-1:0] jump,
  input  logic [EXT_W-1:0]            extent,
  output logic                        done,
  output logic [CO_W-1:0]             wrapped,
  output logic signed [JUMP_BITS-1:0] overlap
);

  // signed sum: full-width coordinate plus carry, and a sign bit
  localparam int SUM_W = (((COORD_W + 1) > JUMP_BITS) ? (COORD_W + 1) : JUMP_BITS) + 1;
  localparam int M_W   = SUM_W - 1;
  localparam logic [M_W:0] LIM = (M_W + 1)'((1 << (JUMP_BITS - 1)) - 1);

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_neg;
  logic [M_W-1:0]       mag;
  logic                 neg;
  logic                 div_done;
  logic [M_W-1:0]       div_quot;
  logic [EXT_W-1:0]     div_rem;
  logic                 borrow;
  logic [M_W:0]         qmag;
  logic [JUMP_BITS-1:0] sat;
  logic [EXT_W-1:0]     fold;

  assign sum     = {{(SUM_W-COORD_W){1'b0}}, coord}
                 + {{(SUM_W-JUMP_BITS){jump[JUMP_BITS-1]}}, jump};
  assign sum_neg = ~sum + 1'b1;
  assign mag     = sum[SUM_W-1] ? sum_neg[M_W-1:0] : sum[M_W-1:0];

  lsj_div #(.N(M_W), .D(EXT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (mag),
    .divisor  (extent),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // floor semantics: a negative sum with a remainder takes one more wrap
  assign borrow = neg && (div_rem != '0);
  assign qmag   = {1'b0, div_quot} + (M_W + 1)'(borrow);
  assign sat    = (qmag > LIM) ? LIM[JUMP_BITS-1:0] : qmag[JUMP_BITS-1:0];
  assign fold   = borrow ? (extent - div_rem) : div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sum[SUM_W-1];
    end
    if (div_done) begin
      wrapped <= fold[CO_W-1:0];
      overlap <= neg ? (~sat + 1'b1) : sat;
    end
  end

endmodule

// ----- src/lsj_pack.sv -----
// Merge stage: packs the four wrapped coordinates back into a linear index.
module lsj_pack #(
  parameter int EXT_W = 7,
  parameter int CO_W  = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [EXT_W-1:0]               radix,
  input  logic [CO_W-1:0]                c_t,
  input  logic [CO_W-1:0]                c_x,
  input  logic [CO_W-1:0]                c_y,
  input  logic [CO_W-1:0]                c_z,
  output logic                           done,
  output logic [lsj_pkg::SITE_BITS-1:0]  site_out
);

  import lsj_pkg::*;

  logic                       run;
  logic [1:0]                 step;
  logic [SITE_BITS-1:0]       acc;
  logic [SITE_BITS+EXT_W-1:0] prod;
  logic [CO_W-1:0]            addend;
  logic [SITE_BITS-1:0]       acc_next;

  assign prod = acc * radix;

  always_comb begin
    unique case (step)
      2'd0:    addend = c_x;
      2'd1:    addend = c_y;
      default: addend = c_z;
    endcase
  end

  assign acc_next = prod[SITE_BITS-1:0] + SITE_BITS'(addend);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        acc  <= SITE_BITS'(c_t);
      end else if (run) begin
        acc  <= acc_next;
        step <= step + 1'b1;
        if (step == 2'd2) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign site_out = acc;

endmodule

// ----- src/lattice_site_jump_periodic.sv -----
// Top level of the periodic 4D lattice site jump block.
//
// Usage: a request (site, jump_t..jump_z) is taken at a rising edge with
// start high and busy low. The site index is split into t,x,y,z with
// spatial_extent as radix, each offset is added and wrapped into its
// direction's extent, and the packed index comes back with four signed,
// saturated wrap counts on dest_site / overlap_*.
// The result is shown for exactly one cycle with done high; the receiver
// cannot stall, so nothing backs up. busy drops in that same cycle and a
// new request may be taken right then.
// One request at a time: busy stays high from accept to done. The work
// is done by bit-serial dividers: one shared divider unpacks the three
// spatial digits, then four lane dividers wrap t, x, y, z side by side
// (t lane is longest), and the merge stage packs x, y and z into the
// index by multiply-add.
// Config: cfg_we/cfg_index/cfg_data write registers 0..4 (spatial_extent,
// extent_t, extent_x, extent_y, extent_z); other indexes are dropped.
// Write only while idle. Zero reads as 1, values above MAX_EXTENT clamp.
// Reset (rst, synchronous): all registers back to 16, control idle.
module lattice_site_jump_periodic #(
  parameter int MAX_EXTENT = lsj_pkg::MAX_EXTENT_DEF,
  parameter int JUMP_BITS  = lsj_pkg::JUMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lsj_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsj_pkg::REG_BITS-1:0]    cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [lsj_pkg::SITE_BITS-1:0]   site,
  input  logic signed [JUMP_BITS-1:0]     jump_t,
  input  logic signed [JUMP_BITS-1:0]     jump_x,
  input  logic signed [JUMP_BITS-1:0]     jump_y,
  input  logic signed [JUMP_BITS-1:0]     jump_z,
  output logic                            done,
  output logic [lsj_pkg::SITE_BITS-1:0]   dest_site,
  output logic signed [JUMP_BITS-1:0]     overlap_t,
  output logic signed [JUMP_BITS-1:0]     overlap_x,
  output logic signed [JUMP_BITS-1:0]     overlap_y,
  output logic signed [JUMP_BITS-1:0]     overlap_z
);

  import lsj_pkg::*;

  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int CO_W  = $clog2(MAX_EXTENT);
  localparam int CMP_W = (REG_BITS > EXT_W) ? REG_BITS : EXT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UNPACK = 4'b0010,
    S_WRAP   = 4'b0100,
    S_PACK   = 4'b1000
  } state_t;

  // zero acts as 1, anything past MAX_EXTENT clamps
  function automatic logic [EXT_W-1:0] eff_ext(input logic [REG_BITS-1:0] raw);
    logic [CMP_W-1:0] wide;
    logic [CMP_W-1:0] clamped;
    wide = CMP_W'(raw);
    if (raw == '0) begin
      clamped = CMP_W'(1);
    end else if (wide > CMP_W'(MAX_EXTENT)) begin
      clamped = CMP_W'(MAX_EXTENT);
    end else begin
      clamped = wide;
    end
    return clamped[EXT_W-1:0];
  endfunction

  // config registers
  logic [REG_BITS-1:0] spatial_extent;
  logic [REG_BITS-1:0] extent_t;
  logic [REG_BITS-1:0] extent_x;
  logic [REG_BITS-1:0] extent_y;
  logic [REG_BITS-1:0] extent_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      spatial_extent <= REG_RESET;
      extent_t       <= REG_RESET;
      extent_x       <= REG_RESET;
      extent_y       <= REG_RESET;
      extent_z       <= REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPATIAL:  spatial_extent <= cfg_data;
        REG_EXTENT_T: extent_t       <= cfg_data;
        REG_EXTENT_X: extent_x       <= cfg_data;
        REG_EXTENT_Y: extent_y       <= cfg_data;
        REG_EXTENT_Z: extent_z       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [EXT_W-1:0] radix;
  logic [EXT_W-1:0] ext_t;
  logic [EXT_W-1:0] ext_x;
  logic [EXT_W-1:0] ext_y;
  logic [EXT_W-1:0] ext_z;

  assign radix = eff_ext(spatial_extent);
  assign ext_t = eff_ext(extent_t);
  assign ext_x = eff_ext(extent_x);
  assign ext_y = eff_ext(extent_y);
  assign ext_z = eff_ext(extent_z);

  state_t                state;
  logic [1:0]            step;
  logic [3:0]            seen;
  logic [JUMP_BITS-1:0]  held_jump_t;
  logic [JUMP_BITS-1:0]  held_jump_x;
  logic [JUMP_BITS-1:0]  held_jump_y;
  logic [JUMP_BITS-1:0]  held_jump_z;
  logic [CO_W-1:0]       digit_y;
  logic [CO_W-1:0]       digit_z;

  logic                  div_start;
  logic [SITE_BITS-1:0]  div_dividend;
  logic                  div_done;
  logic [SITE_BITS-1:0]  div_quot;
  logic [EXT_W-1:0]      div_rem;
  logic                  lane_start;
  logic [3:0]            lane_done;
  logic                  lanes_all;
  logic                  pack_start;
  logic                  pack_done;
  logic [SITE_BITS-1:0]  pack_site;

  logic [CO_W-1:0]       wrap_t;
  logic [CO_W-1:0]       wrap_x;
  logic [CO_W-1:0]       wrap_y;
  logic [CO_W-1:0]       wrap_z;
  logic [JUMP_BITS-1:0]  ovl_t;
  logic [JUMP_BITS-1:0]  ovl_x;
  logic [JUMP_BITS-1:0]  ovl_y;
  logic [JUMP_BITS-1:0]  ovl_z;

  localparam logic [1:0] LAST_DIGIT = 2'd2;

  assign busy      = (state != S_IDLE);
  assign lanes_all = &(seen | lane_done);

  // sequencer strobes: the shared divider runs three times (z, y, x digits),
  // its last quotient is t
  always_comb begin
    div_start    = 1'b0;
    div_dividend = site;
    lane_start   = 1'b0;
    pack_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        div_start = start;
      end
      S_UNPACK: begin
        div_dividend = div_quot;
        if (div_done) begin
          if (step == LAST_DIGIT) begin
            lane_start = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_WRAP: begin
        pack_start = lanes_all;
      end
      S_PACK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      seen  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state       <= S_UNPACK;
            step        <= '0;
            held_jump_t <= jump_t;
            held_jump_x <= jump_x;
            held_jump_y <= jump_y;
            held_jump_z <= jump_z;
          end
        end
        S_UNPACK: begin
          if (div_done) begin
            step <= step + 1'b1;
            if (step == 2'd0) begin
              digit_z <= div_rem[CO_W-1:0];
            end
            if (step == 2'd1) begin
              digit_y <= div_rem[CO_W-1:0];
            end
            if (step == LAST_DIGIT) begin
              state <= S_WRAP;
              seen  <= '0;
            end
          end
        end
        S_WRAP: begin
          seen <= seen | lane_done;
          if (lanes_all) begin
            state <= S_PACK;
          end
        end
        S_PACK: begin
          if (pack_done) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            dest_site <= pack_site;
            overlap_t <= ovl_t;
            overlap_x <= ovl_x;
            overlap_y <= ovl_y;
            overlap_z <= ovl_z;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // shared unpack divider
  lsj_div #(.N(SITE_BITS), .D(EXT_W)) u_unpack (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // four wrap lanes working side by side
  lsj_lane #(.COORD_W(SITE_BITS), .JUMP_BITS(JUMP_BITS), .EXT_W(EXT_W), .CO_W(CO_W))
  u_lane_t (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .coord   (div_quot),
    .jump    (held_jump_t),
    .extent  (ext_t),
    .done    (lane_done[0]),
    .wrapped (wrap_t),
    .overlap (ovl_t)
  );

  lsj_lane #(.COORD_W(CO_W), .JUMP_BITS(JUMP_BITS), .EXT_W(EXT_W), .CO_W(CO_W))
  u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .coord   (div_rem[CO_W-1:0]),
    .jump    (held_jump_x),
    .extent  (ext_x),
    .done    (lane_done[1]),
    .wrapped (wrap_x),
    .overlap (ovl_x)
  );

  lsj_lane #(.COORD_W(CO_W), .JUMP_BITS(JUMP_BITS), .EXT_W(EXT_W), .CO_W(CO_W))
  u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .coord   (digit_y),
    .jump    (held_jump_y),
    .extent  (ext_y),
    .done    (lane_done[2]),
    .wrapped (wrap_y),
    .overlap (ovl_y)
  );

  lsj_lane #(.COORD_W(CO_W), .JUMP_BITS(JUMP_BITS), .EXT_W(EXT_W), .CO_W(CO_W))
  u_lane_z (
    .clk     (clk),
    .rst     (rst),
    .start   (lane_start),
    .coord   (digit_z),
    .jump    (held_jump_z),
    .extent  (ext_z),
    .done    (lane_done[3]),
    .wrapped (wrap_z),
    .overlap (ovl_z)
  );

  // merge: pack wrapped coordinates back into a linear index
  lsj_pack #(.EXT_W(EXT_W), .CO_W(CO_W)) u_pack (
    .clk      (clk),
    .rst      (rst),
    .start    (pack_start),
    .radix    (radix),
    .c_t      (wrap_t),
    .c_x      (wrap_x),
    .c_y      (wrap_y),
    .c_z      (wrap_z),
    .done     (pack_done),
    .site_out (pack_site)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");
`endif

endmodule

// ----- bench/lattice_site_jump_periodic_tb.sv -----
// Self-checking testbench for the periodic 4D lattice site jump block.
`timescale 1ns / 100ps

module lattice_site_jump_periodic_tb;
  import lsj_pkg::*;

  localparam int JB   = JUMP_BITS_DEF;
  localparam int SB   = SITE_BITS;
  // largest wrap count the block can report, both signs
  localparam longint SAT = (64'sd1 <<< (JB - 1)) - 1;
  // accept-to-done time of the block at the default widths
  localparam int LATENCY = 3 * (SB + 1) + (((SB + 1) > JB) ? (SB + 1) : JB) + 6;
  // no request or result for this long means the block hung
  localparam int WATCHDOG_CYCLES = 20 * LATENCY;
  localparam int RANDOM_ITEMS = 1880;

  typedef struct packed {
    logic [SB-1:0]        dest_site;
    logic signed [JB-1:0] overlap_t;
    logic signed [JB-1:0] overlap_x;
    logic signed [JB-1:0] overlap_y;
    logic signed [JB-1:0] overlap_z;
  } jump_result_t;

  // Keeps a shadow of the registers, predicts each request and checks the
  // results in order against the predictions.
  class site_jump_scoreboard;
    logic [REG_BITS-1:0] regs[NUM_REGS];
    jump_result_t        pending_q[$];
    int                  errors;

    function new();
      foreach (regs[i]) regs[i] = REG_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_BITS-1:0] data);
      // indexes past the last register are dropped by the block
      if (idx < NUM_REGS) regs[idx] = data;
    endfunction

    // zero reads as one, anything above MAX_EXTENT clamps
    function longint eff_extent(logic [REG_BITS-1:0] v);
      longint e;
      e = v;
      if (e == 0) e = 1;
      if (e > MAX_EXTENT_DEF) e = MAX_EXTENT_DEF;
      return e;
    endfunction

    function jump_result_t predict_jump(logic [SB-1:0] s, logic signed [JB-1:0] jt,
                                        logic signed [JB-1:0] jx,
                                        logic signed [JB-1:0] jy,
                                        logic signed [JB-1:0] jz);
      longint radix, rest, e, sum, q, linear;
      longint coord[4];
      logic signed [JB-1:0] jmp[4];
      logic signed [JB-1:0] wraps[4];
      jump_result_t r;
      radix = eff_extent(regs[REG_SPATIAL]);
      rest = s;
      coord[3] = rest % radix;
      rest = rest / radix;
      coord[2] = rest % radix;
      rest = rest / radix;
      coord[1] = rest % radix;
      coord[0] = rest / radix;  // t keeps whatever is left, may be huge
      jmp[0] = jt;
      jmp[1] = jx;
      jmp[2] = jy;
      jmp[3] = jz;
      for (int d = 0; d < 4; d++) begin
        e = eff_extent(regs[1 + d]);
        sum = coord[d] + longint'(jmp[d]);
        // floor division, then the remainder is always in [0, e)
        q = sum / e;
        if ((sum % e) != 0 && sum < 0) q = q - 1;
        coord[d] = sum - q * e;
        if (q > SAT) q = SAT;
        if (q < -SAT) q = -SAT;
        wraps[d] = q[JB-1:0];
      end
      linear = coord[0];
      for (int d = 1; d < 4; d++) linear = linear * radix + coord[d];
      r.dest_site = linear[SB-1:0];
      r.overlap_t = wraps[0];
      r.overlap_x = wraps[1];
      r.overlap_y = wraps[2];
      r.overlap_z = wraps[3];
      return r;
    endfunction

    function void note_request(logic [SB-1:0] s, logic signed [JB-1:0] jt,
                               logic signed [JB-1:0] jx, logic signed [JB-1:0] jy,
                               logic signed [JB-1:0] jz);
      pending_q.push_back(predict_jump(s, jt, jx, jy, jz));
    endfunction

    function void check_result(jump_result_t got);
      jump_result_t want;
      if (pending_q.size() == 0) begin
        $error("unrequested result: dest_site %0d", got.dest_site);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.dest_site !== want.dest_site) begin
        $error("dest_site: expected %0d, actual %0d", want.dest_site, got.dest_site);
        errors++;
      end
      if (got.overlap_t !== want.overlap_t) begin
        $error("overlap_t: expected %0d, actual %0d", want.overlap_t, got.overlap_t);
        errors++;
      end
      if (got.overlap_x !== want.overlap_x) begin
        $error("overlap_x: expected %0d, actual %0d", want.overlap_x, got.overlap_x);
        errors++;
      end
      if (got.overlap_y !== want.overlap_y) begin
        $error("overlap_y: expected %0d, actual %0d", want.overlap_y, got.overlap_y);
        errors++;
      end
      if (got.overlap_z !== want.overlap_z) begin
        $error("overlap_z: expected %0d, actual %0d", want.overlap_z, got.overlap_z);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SPATIAL;
  logic [REG_BITS-1:0]   cfg_data  = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  logic [SB-1:0]         site      = '0;
  logic signed [JB-1:0]  jump_t    = '0;
  logic signed [JB-1:0]  jump_x    = '0;
  logic signed [JB-1:0]  jump_y    = '0;
  logic signed [JB-1:0]  jump_z    = '0;
  logic                  done;
  logic [SB-1:0]         dest_site;
  logic signed [JB-1:0]  overlap_t;
  logic signed [JB-1:0]  overlap_x;
  logic signed [JB-1:0]  overlap_y;
  logic signed [JB-1:0]  overlap_z;

  site_jump_scoreboard sb = new();

  bit           no_idle = 1'b0;   // burst stretch: sender never pauses
  int           stall_cycles = 0;
  jump_result_t seen_result;
  int           random_total;
  int           phase_len;

  lattice_site_jump_periodic dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .site      (site),
    .jump_t    (jump_t),
    .jump_x    (jump_x),
    .jump_y    (jump_y),
    .jump_z    (jump_z),
    .done      (done),
    .dest_site (dest_site),
    .overlap_t (overlap_t),
    .overlap_x (overlap_x),
    .overlap_y (overlap_y),
    .overlap_z (overlap_z)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Results: done marks a one-cycle strobe, taken at the edge ending it.
  // Reading at the posedge sees the values from before the edge.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      seen_result.dest_site = dest_site;
      seen_result.overlap_t = overlap_t;
      seen_result.overlap_x = overlap_x;
      seen_result.overlap_y = overlap_y;
      seen_result.overlap_z = overlap_z;
      sb.check_result(seen_result);
    end
  end

  // Watchdog: any accepted request, result or reset clears the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1 || rst) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks: inputs move on the falling edge
  // ---------------------------------------------------------------------

  // One request. Gap is drawn per request; sometimes the sender first waits
  // for the block to finish so the gap lands around done / busy falling.
  task automatic issue(input logic [SB-1:0] s, input int jt, input int jx,
                       input int jy, input int jz);
    int gap;
    bit hold;
    gap  = no_idle ? 0 : $urandom_range(10, 0);
    hold = !no_idle && ($urandom_range(3, 0) == 0);
    if (hold && gap == 0) gap = 1;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      while (hold && sb.pending() != 0) @(negedge clk);
      repeat (gap - 1) @(negedge clk);
    end
    site   = s;
    jump_t = JB'(jt);
    jump_x = JB'(jx);
    jump_y = JB'(jy);
    jump_z = JB'(jz);
    start  = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(site, jump_t, jump_x, jump_y, jump_z);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all five registers; optionally one stray write past the last
  // index, which the block must drop.
  task automatic program_regs(input int sp, input int et, input int ex,
                              input int ey, input int ez, input bit stray);
    logic [CFG_IDX_W-1:0] ids[NUM_REGS];
    logic [REG_BITS-1:0]  vals[NUM_REGS];
    ids[0] = REG_SPATIAL;
    ids[1] = REG_EXTENT_T;
    ids[2] = REG_EXTENT_X;
    ids[3] = REG_EXTENT_Y;
    ids[4] = REG_EXTENT_Z;
    vals[0] = REG_BITS'(sp);
    vals[1] = REG_BITS'(et);
    vals[2] = REG_BITS'(ex);
    vals[3] = REG_BITS'(ey);
    vals[4] = REG_BITS'(ez);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = ids[i];
      cfg_data  = vals[i];
      @(posedge clk);
      sb.write_reg(cfg_index, cfg_data);
    end
    if (stray) begin
      @(negedge clk);
      cfg_index = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS));
      cfg_data  = REG_BITS'($urandom_range(0, 1));  // 0 or 1 would be very visible
      @(posedge clk);
      sb.write_reg(cfg_index, cfg_data);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Register value: mostly legal extents, with zero, one, the clamp edge
  // and out-of-range values mixed in.
  function automatic int pick_reg();
    case ($urandom_range(9, 0))
      0: return 0;
      1: return 1;
      2: return MAX_EXTENT_DEF;
      3: return $urandom_range((1 << REG_BITS) - 1, MAX_EXTENT_DEF + 1);
      4: return $urandom_range(4, 2);
      default: return $urandom_range(MAX_EXTENT_DEF, 1);
    endcase
  endfunction

  // Site index: mostly a real lattice site, some corners, some raw noise.
  function automatic logic [SB-1:0] pick_site();
    longint r, et, lin;
    longint c[4];
    int mode;
    r  = sb.eff_extent(sb.regs[REG_SPATIAL]);
    et = sb.eff_extent(sb.regs[REG_EXTENT_T]);
    mode = $urandom_range(19, 0);
    if (mode < 3) return SB'($urandom);
    for (int d = 0; d < 4; d++) begin
      if (mode < 6) begin
        c[d] = $urandom_range(1, 0) ? 0 : ((d == 0) ? et : r) - 1;
      end else begin
        c[d] = $urandom_range(((d == 0) ? et : r) - 1, 0);
      end
    end
    lin = ((c[0] * r + c[1]) * r + c[2]) * r + c[3];
    return lin[SB-1:0];
  endfunction

  // Offset: mostly a few extents either way so wraps happen often, plus
  // the full field range and its extremes.
  function automatic int pick_jump(longint e);
    int mode, span;
    mode = $urandom_range(19, 0);
    if (mode < 2) begin
      case ($urandom_range(4, 0))
        0: return SAT;
        1: return -SAT;
        2: return 0;
        3: return 1;
        default: return -1;
      endcase
    end
    if (mode < 6) return int'($urandom_range(2 * SAT, 0)) - SAT;
    span = 2 * e + 1;
    if (span > SAT) span = SAT;
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values, 16 everywhere: basic wraps both ways, huge t quotient
    issue(24'h000000, 0, 0, 0, 0);
    issue(24'h000000, -1, -1, -1, -1);
    issue(24'h00FFFF, 1, 1, 1, 1);
    issue(24'hFFFFFF, 127, 127, 127, 127);
    issue(24'h5A5A5A, -127, -127, -127, -127);
    issue(24'd12345, 127, -127, 16, -16);

    // zero registers behave as extent one
    settle();
    program_regs(0, 0, 0, 0, 0, 1'b0);
    issue(24'hFFFFFF, -127, 127, 0, -1);
    issue(24'h123456, 5, -5, 127, -127);

    // values above the maximum clamp; stray index write must not land
    settle();
    program_regs(127, 65, 127, 100, 66, 1'b1);
    issue(24'hFFFFFF, 127, 127, 127, 127);
    issue(24'h000000, -127, -64, -65, 63);
    issue(24'h3F3F3F, 1, 1, 1, 1);

    // radix one: everything sits in t, which is far outside its extent
    settle();
    program_regs(1, 64, 64, 64, 64, 1'b0);
    issue(24'hFFFFFF, 0, 0, 0, 0);
    issue(24'h800000, 127, 127, 127, 127);
    issue(24'd5, -127, 63, 64, -65);

    // extents larger than the radix: coordinates pack past their digit
    settle();
    program_regs(4, 64, 64, 64, 64, 1'b1);
    issue(24'd255, 60, 60, 60, 60);
    issue(24'h000000, -1, 127, -127, 100);
    issue(24'hABCDEF, 3, 3, 3, 3);

    // tiny extents: wrap counts run into saturation
    settle();
    program_regs(64, 1, 2, 3, 1, 1'b0);
    issue(24'hFFFFFF, 127, 127, 127, 127);
    issue(24'h000000, -127, -127, -127, -127);
    issue(24'h0FFFFF, 127, -127, -100, 100);

    // random phases, each with its own register setting
    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      settle();
      program_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                   $urandom_range(2, 0) == 0);
      phase_len = $urandom_range(145, 90);
      for (int k = 0; k < phase_len; k++) begin
        if (k % 30 == 0) no_idle = ($urandom_range(3, 0) == 0);
        issue(pick_site(),
              pick_jump(sb.eff_extent(sb.regs[REG_EXTENT_T])),
              pick_jump(sb.eff_extent(sb.regs[REG_EXTENT_X])),
              pick_jump(sb.eff_extent(sb.regs[REG_EXTENT_Y])),
              pick_jump(sb.eff_extent(sb.regs[REG_EXTENT_Z])));
      end
      random_total += phase_len;
    end

    // drain, then give any stray result time to show up
    settle();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.pending() != 0) $error("%0d requests never answered", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
